[hw/rtl/cdes_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdes_pkg: shared constants, types and tables for the epoch-seconds core
// Holds field widths, calendar constants, the reciprocal used for the
// divisions by one hundred and the cumulative month table.
// ----------------------------------------------------------------------------
package cdes_pkg;

  localparam int YearW   = 12;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;
  localparam int OutW    = 37;

  // Years above this value are clamped to it.
  localparam int MaxYear   = 4095;
  localparam int EpochYear = 1970;

  // Day number of 1970-01-01 counted from 0000-01-01.
  localparam int EpochDays = 365 * EpochYear + (EpochYear + 3) / 4
                           - (EpochYear + 99) / 100 + (EpochYear + 399) / 400;

  localparam int DaysW = 22;   // signed day count relative to the epoch
  localparam int TodW  = 17;   // seconds within the day, unclamped fields
  localparam int ProdW = 25;   // reciprocal products
  localparam int DivShift = 19;
  localparam int QuotW = ProdW - DivShift;

  // ceil(2^19 / 100): exact floor division by 100 for operands below 43690.
  localparam logic [ProdW-1:0] Recip100 = ProdW'(5243);

  localparam logic [MonthW-1:0] MonthJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(12);

  localparam int SecsPerDay  = 86400;
  localparam int SecsPerHour = 3600;
  localparam int SecsPerMin  = 60;

  typedef struct packed {
    logic signed [DaysW-1:0] days;
    logic [TodW-1:0]         tod;
  } cdes_day_t;

  // Days in the months before the given month of a common year.
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] mon);
    logic [8:0] d;
    case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/cdes_day_count.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdes_day_count: two-stage day counter
// Clamps the year and month, forms the day number relative to the epoch and
// the seconds within the day.
// ----------------------------------------------------------------------------
module cdes_day_count (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [cdes_pkg::YearW-1:0]        in_year,
  input  wire  [cdes_pkg::MonthW-1:0]       in_month,
  input  wire  [cdes_pkg::DayW-1:0]         in_day,
  input  wire  [cdes_pkg::HourW-1:0]        in_hour,
  input  wire  [cdes_pkg::MinuteW-1:0]      in_minute,
  input  wire  [cdes_pkg::SecondW-1:0]      in_second,
  output logic                              dn_valid,
  input  wire                               dn_ready,
  output cdes_pkg::cdes_day_t               dn_data
);
  import cdes_pkg::*;

  // Stage one.
  logic                    s1_v_r, s1_v_nxt, s1_rdy;
  logic [YearW-1:0]        s1_year_r, s1_year_nxt;
  logic                    s1_late_r, s1_late_nxt;
  logic [DaysW-1:0]        s1_base_r, s1_base_nxt;
  logic [ProdW-1:0]        s1_pa_r, s1_pa_nxt;
  logic [ProdW-1:0]        s1_pb_r, s1_pb_nxt;
  logic [ProdW-1:0]        s1_pc_r, s1_pc_nxt;
  logic [HourW-1:0]        s1_hour_r;
  logic [MinuteW-1:0]      s1_minute_r;
  logic [SecondW-1:0]      s1_second_r;
  logic [MonthW-1:0]       mon_c;

  // Stage two.
  logic                    s2_v_r, s2_v_nxt, s2_rdy;
  cdes_day_t               s2_data_r, s2_data_nxt;
  logic [QuotW-1:0]        q_a, q_b, q_c;
  logic [12:0]             hund;
  logic                    rem_zero, leap;

  assign s2_rdy   = !s2_v_r || dn_ready;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;
  assign dn_valid = s2_v_r;
  assign dn_data  = s2_data_r;

  always_comb begin
    s1_year_nxt = (32'(in_year) > MaxYear) ? YearW'(MaxYear) : in_year;
    if (in_month < MonthJan) begin
      mon_c = MonthJan;
    end else if (in_month > MonthDec) begin
      mon_c = MonthDec;
    end else begin
      mon_c = in_month;
    end
    s1_late_nxt = (mon_c > MonthFeb);
    s1_base_nxt = DaysW'(s1_year_nxt) * DaysW'(365)
                + DaysW'((13'(s1_year_nxt) + 13'd3) >> 2)
                + DaysW'(days_before(mon_c))
                + DaysW'(in_day)
                - DaysW'(EpochDays + 1);
    s1_pa_nxt = ProdW'(13'(s1_year_nxt) + 13'd99) * Recip100;
    s1_pb_nxt = ProdW'((13'(s1_year_nxt) + 13'd399) >> 2) * Recip100;
    s1_pc_nxt = ProdW'(s1_year_nxt) * Recip100;
    s1_v_nxt  = s1_rdy ? in_valid : s1_v_r;
  end

  always_comb begin
    q_a      = s1_pa_r[ProdW-1:DivShift];
    q_b      = s1_pb_r[ProdW-1:DivShift];
    q_c      = s1_pc_r[ProdW-1:DivShift];
    hund     = 13'(q_c) * 13'd100;
    rem_zero = (13'(s1_year_r) == hund);
    leap     = ((s1_year_r[1:0] == 2'b00) && !rem_zero)
            || (rem_zero && (q_c[1:0] == 2'b00));
    s2_data_nxt.days = $signed(s1_base_r - DaysW'(q_a) + DaysW'(q_b)
                             + DaysW'(leap && s1_late_r));
    s2_data_nxt.tod  = TodW'(s1_hour_r) * TodW'(SecsPerHour)
                     + TodW'(s1_minute_r) * TodW'(SecsPerMin)
                     + TodW'(s1_second_r);
    s2_v_nxt = s2_rdy ? s1_v_r : s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_year_r   <= s1_year_nxt;
      s1_late_r   <= s1_late_nxt;
      s1_base_r   <= s1_base_nxt;
      s1_pa_r     <= s1_pa_nxt;
      s1_pb_r     <= s1_pb_nxt;
      s1_pc_r     <= s1_pc_nxt;
      s1_hour_r   <= in_hour;
      s1_minute_r <= in_minute;
      s1_second_r <= in_second;
    end
    if (s2_rdy && s1_v_r) begin
      s2_data_r <= s2_data_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cdes_sec_scale.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdes_sec_scale: two-stage seconds scaler
// Multiplies the day count by the seconds in a day, then adds the seconds
// within the day into the output register.
// ----------------------------------------------------------------------------
module cdes_sec_scale (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               up_valid,
  output logic                              up_ready,
  input  cdes_pkg::cdes_day_t               up_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [cdes_pkg::OutW-1:0]  out_epoch_seconds
);
  import cdes_pkg::*;

  localparam int MulW = 40;
  localparam logic signed [MulW-1:0] DaySecs = MulW'(SecsPerDay);

  logic                    s3_v_r, s3_v_nxt, s3_rdy;
  logic [OutW-1:0]         s3_prod_r, s3_prod_nxt;
  logic [TodW-1:0]         s3_tod_r;
  logic signed [MulW-1:0]  days_ext, prod_full;

  logic                    s4_v_r, s4_v_nxt, s4_rdy;
  logic [OutW-1:0]         s4_sum_r, s4_sum_nxt;

  assign s4_rdy    = !s4_v_r || out_ready;
  assign s3_rdy    = !s3_v_r || s4_rdy;
  assign up_ready  = s3_rdy;
  assign out_valid = s4_v_r;
  assign out_epoch_seconds = $signed(s4_sum_r);

  always_comb begin
    days_ext    = MulW'(up_data.days);
    prod_full   = days_ext * DaySecs;
    s3_prod_nxt = prod_full[OutW-1:0];
    s3_v_nxt    = s3_rdy ? up_valid : s3_v_r;
    s4_sum_nxt  = s3_prod_r + OutW'(s3_tod_r);
    s4_v_nxt    = s4_rdy ? s3_v_r : s4_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s3_v_r <= s3_v_nxt;
      s4_v_r <= s4_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && up_valid) begin
      s3_prod_r <= s3_prod_nxt;
      s3_tod_r  <= up_data.tod;
    end
    if (s4_rdy && s3_v_r) begin
      s4_sum_r <= s4_sum_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/calendar_date_to_epoch_seconds_core.sv]
`default_nettype none
// Throughput: one transfer per cycle while the output is not stalled; four
// register stages, each with its own valid bit, and a stage takes new data
// whenever it is empty or its successor takes its contents, so a stall
// loses and repeats nothing. Reset (rst_n, synchronous, active low) clears
// every stage valid bit; the data registers are not reset. No state
// outlives an item.
// ----------------------------------------------------------------------------
// calendar_date_to_epoch_seconds_core: Gregorian date to Unix seconds
// Converts a civil date and time into signed seconds since 1970-01-01.
// ----------------------------------------------------------------------------
module calendar_date_to_epoch_seconds_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [cdes_pkg::YearW-1:0]        in_year,
  input  wire  [cdes_pkg::MonthW-1:0]       in_month,
  input  wire  [cdes_pkg::DayW-1:0]         in_day,
  input  wire  [cdes_pkg::HourW-1:0]        in_hour,
  input  wire  [cdes_pkg::MinuteW-1:0]      in_minute,
  input  wire  [cdes_pkg::SecondW-1:0]      in_second,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [cdes_pkg::OutW-1:0]  out_epoch_seconds
);
  import cdes_pkg::*;

  // The day counter hands the signed day number (relative to the epoch) and
  // the seconds within the day to the scaler as one bundle.
  logic       day_valid;
  logic       day_ready;
  cdes_day_t  day_data;

  // Stages one and two: the year is clamped to the supported range and the
  // month to January..December. The day number is built from the closed
  // form 365*y + ceil(y/4) - ceil(y/100) + ceil(y/400); the divisions by one
  // hundred and four hundred use a reciprocal multiply in stage one and a
  // shift in stage two, where the leap-day correction for March onwards is
  // also added. Days outside a month's length simply run on linearly.
  cdes_day_count u_day_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_year   (in_year),
    .in_month  (in_month),
    .in_day    (in_day),
    .in_hour   (in_hour),
    .in_minute (in_minute),
    .in_second (in_second),
    .dn_valid  (day_valid),
    .dn_ready  (day_ready),
    .dn_data   (day_data)
  );

  // Stages three and four: one signed multiply by 86400, registered, then
  // the seconds within the day are added into the output register. The
  // result is taken modulo 2^37, which holds every reachable value.
  cdes_sec_scale u_sec_scale (
    .clk               (clk),
    .rst_n             (rst_n),
    .up_valid          (day_valid),
    .up_ready          (day_ready),
    .up_data           (day_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_epoch_seconds (out_epoch_seconds)
  );

endmodule
`default_nettype wire

[hw/rtl/cdes_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdes_checker: port-level checks for the epoch-seconds core
// Watches reset, flow-through of the pipeline and output stalls.
// ----------------------------------------------------------------------------
module cdes_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire signed [cdes_pkg::OutW-1:0]   out_epoch_seconds
);

  // Reset empties the pipeline.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // A ready sink lets every stage move, so the input side must be ready.
  a_ready_flows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input not ready while the output drains");

  // With the sink ready, an accepted item moves through every stage without a stall and is offered at the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid)
    else $error("accepted item did not reach the output in four cycles");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_epoch_seconds)))
    else $error("stalled result dropped or changed");

endmodule

bind calendar_date_to_epoch_seconds_core cdes_checker u_cdes_checker (.*);
`default_nettype wire

[dv/tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for calendar_date_to_epoch_seconds_core
// Feeds civil dates and times through the valid/ready input channel, predicts
// the signed seconds since 1970-01-01 for each transfer and checks every
// result in order. A directed table comes first, then random dates in four
// phases that vary the idling on the input and result channels.
// ----------------------------------------------------------------------------
module tb;

  import cdes_pkg::*;

  // Directed rows run with no idling; each of the four phases then adds this
  // many random dates, giving roughly 1450 random items in all.
  localparam int RandomPerPhase = 362;
  // Cycles without any transfer on either channel before the run is given up.
  localparam int IdleLimit = 2000;
  // The pipeline is four stages deep; wait a little longer for strays.
  localparam int DrainCycles = 12;

  // Day of the year on which each month starts, for a common year.
  localparam int CommonMonthStart [12] = '{0, 31, 59, 90, 120, 151,
                                            181, 212, 243, 273, 304, 334};

  // One civil date and time, as it crosses the input channel.
  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] sec;
  } civil_time_t;

  // A row of the directed table. Where fixed is set, the expected count is
  // typed in; otherwise it comes from the predictor.
  typedef struct {
    civil_time_t             stamp;
    bit                      fixed;
    logic signed [OutW-1:0]  epoch;
  } date_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [YearW-1:0]           in_year = '0;
  logic [MonthW-1:0]          in_month = '0;
  logic [DayW-1:0]            in_day = '0;
  logic [HourW-1:0]           in_hour = '0;
  logic [MinuteW-1:0]         in_minute = '0;
  logic [SecondW-1:0]         in_second = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [OutW-1:0]     out_epoch_seconds;

  // Expected epoch counts, oldest first, one per accepted input transfer.
  logic signed [OutW-1:0]     pending_epoch_q [$];
  date_row_t                  date_table_q [$];
  int unsigned                send_idle_pct = 0;
  int unsigned                recv_stall_pct = 0;
  int                         failures = 0;
  int                         quiet_cycles = 0;

  calendar_date_to_epoch_seconds_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_year           (in_year),
    .in_month          (in_month),
    .in_day            (in_day),
    .in_hour           (in_hour),
    .in_minute         (in_minute),
    .in_second         (in_second),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_epoch_seconds (out_epoch_seconds)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Calendar arithmetic for the predictor.
  // --------------------------------------------------------------------------

  // Gregorian rule: every fourth year, except centuries not divisible by 400.
  // Year zero is a leap year under this rule.
  function automatic bit is_leap_year(input longint yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  // Days from 0000-01-01 to the first of January of the given year. The
  // rounded-up divisions count the leap years strictly before it.
  function automatic longint days_from_year_zero(input longint yr);
    return 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
  endfunction

  function automatic int month_length(input int yr, input int mon);
    int len;
    len = (mon == 12) ? 31 : CommonMonthStart[mon] - CommonMonthStart[mon-1];
    if (mon == 2 && is_leap_year(longint'(yr))) len = len + 1;
    return len;
  endfunction

  // Expected seconds since the epoch. Out-of-range months are pulled to
  // January or December; out-of-range days and times simply run on, so day
  // zero is the day before the first and hour 31 lands in the next day.
  function automatic logic signed [OutW-1:0] epoch_seconds_of(input civil_time_t t);
    longint yr;
    longint days;
    longint total;
    int     mon;
    yr = longint'(t.year);
    if (yr > longint'(MaxYear)) yr = longint'(MaxYear);
    mon = int'(t.month);
    if (mon < int'(MonthJan)) mon = int'(MonthJan);
    if (mon > int'(MonthDec)) mon = int'(MonthDec);
    days = days_from_year_zero(yr) - days_from_year_zero(longint'(EpochYear));
    days = days + longint'(CommonMonthStart[mon-1]);
    if (mon > int'(MonthFeb) && is_leap_year(yr)) days = days + 1;
    days = days + longint'(t.day) - 1;
    total = days * 86400 + longint'(t.hour) * 3600 + longint'(t.minute) * 60
          + longint'(t.sec);
    return total[OutW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------

  task automatic table_row(input int yr, input int mon, input int dd, input int hh,
                           input int mm, input int ss, input bit fixed,
                           input longint epoch);
    date_row_t row;
    row.stamp.year   = YearW'(yr);
    row.stamp.month  = MonthW'(mon);
    row.stamp.day    = DayW'(dd);
    row.stamp.hour   = HourW'(hh);
    row.stamp.minute = MinuteW'(mm);
    row.stamp.sec    = SecondW'(ss);
    row.fixed        = fixed;
    row.epoch        = epoch[OutW-1:0];
    date_table_q.push_back(row);
  endtask

  // Most random items are real calendar dates, with years bunched around the
  // epoch, the leap-year boundaries and the whole range. The rest are raw bit
  // patterns, which reach month zero, months above twelve, day zero and the
  // overlong times.
  function automatic civil_time_t random_civil_time();
    civil_time_t t;
    int          yr;
    int          mon;
    if ($urandom_range(99) < 80) begin
      case ($urandom_range(3))
        0:       yr = int'($urandom_range(4095));
        1:       yr = int'($urandom_range(2100, 1900));
        2:       yr = int'($urandom_range(40)) * 100 + int'($urandom_range(4));
        default: yr = int'($urandom_range(1980, 1960));
      endcase
      mon      = int'($urandom_range(12, 1));
      t.year   = YearW'(yr);
      t.month  = MonthW'(mon);
      t.day    = DayW'($urandom_range(month_length(yr, mon), 1));
      t.hour   = HourW'($urandom_range(23));
      t.minute = MinuteW'($urandom_range(59));
      t.sec    = SecondW'($urandom_range(59));
    end else begin
      t.year   = YearW'($urandom);
      t.month  = MonthW'($urandom);
      t.day    = DayW'($urandom);
      t.hour   = HourW'($urandom);
      t.minute = MinuteW'($urandom);
      t.sec    = SecondW'($urandom);
    end
    return t;
  endfunction

  // Offers one date on the input channel, starting at a falling edge, and
  // records its expected count at the rising edge where the transfer happens.
  // Valid is only lowered when an idle gap is actually taken, so back-to-back
  // items keep it high without a glitch.
  task automatic transfer_date(input civil_time_t t, input bit fixed,
                               input logic signed [OutW-1:0] fixed_epoch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_year   <= t.year;
    in_month  <= t.month;
    in_day    <= t.day;
    in_hour   <= t.hour;
    in_minute <= t.minute;
    in_second <= t.sec;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_epoch_q.push_back(fixed ? fixed_epoch : epoch_seconds_of(t));
    @(negedge clk);
  endtask

  // The receiver decides afresh at every falling edge whether to stall.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Checking. Results must arrive in order, one per input transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    logic signed [OutW-1:0] want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_epoch_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result transfer: epoch_seconds %0d at %0t",
                   out_epoch_seconds, $time);
      end else begin
        want = pending_epoch_q.pop_front();
        if (out_epoch_seconds !== want) begin
          failures++;
          if (failures <= 10)
            $display("epoch_seconds mismatch at %0t: expected %0d, got %0d",
                     $time, want, out_epoch_seconds);
        end
      end
    end
  end

  // A hung handshake shows up as a long run of cycles with no transfer at all.
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", IdleLimit);
      $display("calendar_date_to_epoch_seconds_core verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of the run.
  // --------------------------------------------------------------------------
  initial begin
    int phase;

    // Epoch, its neighbours and the ends of the representable range.
    table_row(1970,  1,  1,  0,  0,  0, 1'b1, 0);
    table_row(1969, 12, 31, 23, 59, 59, 1'b1, -1);
    table_row(1969,  1,  1,  0,  0,  0, 1'b1, -31536000);
    table_row(   0,  1,  1,  0,  0,  0, 1'b1, -64'sd62167219200);
    table_row(4095, 12, 31, 23, 59, 59, 1'b1, 64'sd67090118399);
    // Leap years: divisible by 400, by 100 only, year zero, and February
    // the 29th on both sides of the epoch.
    table_row(2000,  1,  1,  0,  0,  0, 1'b1, 946684800);
    table_row(2000,  3,  1,  0,  0,  0, 1'b1, 951868800);
    table_row(1900,  3,  1,  0,  0,  0, 1'b0, 0);
    table_row(2100,  2, 28, 12, 30, 30, 1'b0, 0);
    table_row(2100,  3,  1,  0,  0,  0, 1'b0, 0);
    table_row(1968,  2, 29, 12,  0,  0, 1'b0, 0);
    table_row(1968,  3,  1,  0,  0,  1, 1'b0, 0);
    table_row(2024,  2, 29, 23, 59, 59, 1'b0, 0);
    table_row(   0,  3,  1,  0,  0,  0, 1'b0, 0);
    table_row(1972, 12, 31, 23, 59, 59, 1'b0, 0);
    // Month zero counts as January, months above twelve as December.
    table_row(1970,  0,  1,  0,  0,  0, 1'b1, 0);
    table_row(1970, 15,  1,  0,  0,  0, 1'b1, 28857600);
    table_row(1970, 13, 31,  0,  0,  0, 1'b0, 0);
    // Day zero and days past the month end run on linearly, as do times.
    table_row(1970,  1,  0,  0,  0,  0, 1'b1, -86400);
    table_row(1970,  2, 31,  0,  0,  0, 1'b0, 0);
    table_row(1970,  1,  1, 31, 63, 63, 1'b1, 115443);
    table_row(   0,  0,  0,  0,  0,  0, 1'b0, 0);
    table_row(4095, 15, 31, 31, 63, 63, 1'b0, 0);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (date_table_q[i])
      transfer_date(date_table_q[i].stamp, date_table_q[i].fixed, date_table_q[i].epoch);

    // Phase 0 runs flat out, then the sender idles, then the receiver stalls,
    // then both hold back now and again.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
      endcase
      repeat (RandomPerPhase) transfer_date(random_civil_time(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_epoch_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (failures == 0)
      $display("calendar_date_to_epoch_seconds_core verification clean");
    else
      $display("calendar_date_to_epoch_seconds_core verification failed");
    $finish;
  end

endmodule
`default_nettype wire

[calendar_date_to_epoch_seconds_core.f]
hw/rtl/cdes_pkg.sv
hw/rtl/cdes_day_count.sv
hw/rtl/cdes_sec_scale.sv
hw/rtl/calendar_date_to_epoch_seconds_core.sv
hw/rtl/cdes_checker.sv
dv/tb.sv
